// ===== rtl/core/tsit_pkg.sv =====
package tsit_pkg;

    // Table geometry
    localparam int DEPTH      = 8;
    localparam int NAME_CHARS = 8;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    localparam logic [63:0] BLANK_NAME = 64'h0000_0000_002D_2D2D;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_READ    = 2'd1,
        OP_QUALIFY = 2'd2
    } op_t;

    typedef struct packed {
        logic signed [31:0] score;
        logic [15:0]        level;
        logic [15:0]        lines;
        logic [63:0]        name;
    } rec_t;

    typedef struct packed {
        op_t        op;
        rec_t       rec;
        logic [7:0] entry_index;
    } item_t;

    typedef struct packed {
        logic               placed;
        logic [5:0]         rank;
        logic               qualifies;
        logic               entry_valid;
        logic signed [31:0] entry_score;
        logic [15:0]        entry_level;
        logic [15:0]        entry_lines;
        logic [63:0]        entry_name;
        logic [6:0]         fill_count;
        logic signed [31:0] best_score;
    } rsp_t;

    typedef struct packed {
        logic wr_en;
        idx_t wr_addr;
        logic rd_en;
        idx_t rd_addr;
    } mem_ctl_t;

    typedef struct packed {
        logic start;
        logic out_free;
    } seq_cmd_t;

    typedef struct packed {
        logic idle;
        logic done;
    } seq_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_PLACE,
        ST_FETCH_USE,
        ST_DONE
    } state_t;

    // Blank names become "---"; clear everything after the first zero byte
    function automatic logic [63:0] clean_name(input logic [63:0] raw);
        logic [63:0] src;
        logic [63:0] res;
        logic        live;
        src  = (raw[7:0] == 8'h00) ? BLANK_NAME : raw;
        res  = '0;
        live = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            if (src[8*i +: 8] == 8'h00)
            begin
                live = 1'b0;
            end
            if (live && (i < NAME_CHARS))
            begin
                res[8*i +: 8] = src[8*i +: 8];
            end
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/tsit_if.sv =====
interface tsit_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic signed [31:0] score;
    logic [15:0]        level;
    logic [15:0]        lines;
    logic [63:0]        name_bytes;
    logic [7:0]         entry_index;

    modport source (output valid, op, score, level, lines, name_bytes, entry_index,
                    input ready);
    modport sink   (input valid, op, score, level, lines, name_bytes, entry_index,
                    output ready);
endinterface

interface tsit_rsp_if;
    logic               valid;
    logic               ready;
    logic               placed;
    logic [5:0]         rank;
    logic               qualifies;
    logic               entry_valid;
    logic signed [31:0] entry_score;
    logic [15:0]        entry_level;
    logic [15:0]        entry_lines;
    logic [63:0]        entry_name;
    logic [6:0]         fill_count;
    logic signed [31:0] best_score;

    modport source (output valid, placed, rank, qualifies, entry_valid, entry_score,
                    entry_level, entry_lines, entry_name, fill_count, best_score,
                    input ready);
    modport sink   (input valid, placed, rank, qualifies, entry_valid, entry_score,
                    entry_level, entry_lines, entry_name, fill_count, best_score,
                    output ready);
endinterface

// ===== rtl/core/tsit_store.sv =====
module tsit_store (
    input  logic               clk,
    input  tsit_pkg::mem_ctl_t ctl,
    input  tsit_pkg::rec_t     wr_data,
    output tsit_pkg::rec_t     rd_data
);

    tsit_pkg::rec_t mem [tsit_pkg::DEPTH];
    tsit_pkg::rec_t rd_data_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[ctl.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/tsit_seq.sv =====
module tsit_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  tsit_pkg::seq_cmd_t  cmd,
    input  tsit_pkg::item_t     item,
    output tsit_pkg::seq_stat_t stat,
    output tsit_pkg::rsp_t      rsp
);

    localparam tsit_pkg::cnt_t DEPTH_CNT = tsit_pkg::cnt_t'(tsit_pkg::DEPTH);
    localparam tsit_pkg::idx_t LAST_IDX  = tsit_pkg::idx_t'(tsit_pkg::DEPTH - 1);

    tsit_pkg::state_t   state_reg, state_next;
    tsit_pkg::item_t    item_reg, item_next;
    tsit_pkg::cnt_t     cnt_reg, cnt_next;
    tsit_pkg::cnt_t     ptr_reg, ptr_next;
    tsit_pkg::cnt_t     rank_reg, rank_next;
    logic signed [31:0] best_reg, best_next;
    tsit_pkg::rsp_t     res_reg, res_next;

    tsit_pkg::mem_ctl_t mem_ctl;
    tsit_pkg::rec_t     wr_data;
    tsit_pkg::rec_t     rd_data;

    logic               cmp_gt;
    logic               scan_end;
    logic               read_hit;
    logic               full;
    tsit_pkg::cnt_t     shift_last;

    tsit_store u_store (
        .clk     (clk),
        .ctl     (mem_ctl),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    // Shared signed compare against the entry just read
    assign cmp_gt     = item_reg.rec.score > rd_data.score;
    assign scan_end   = (ptr_reg == cnt_reg);
    assign full       = (cnt_reg == DEPTH_CNT);
    assign read_hit   = item.entry_index < 8'(cnt_reg);
    assign shift_last = full ? (DEPTH_CNT - 1'b1) : cnt_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tsit_pkg::ST_IDLE:
            begin
                if (cmd.start)
                begin
                    priority case (item.op)
                        tsit_pkg::OP_INSERT:  state_next = tsit_pkg::ST_SCAN_RD;
                        tsit_pkg::OP_READ:
                            state_next = read_hit ? tsit_pkg::ST_FETCH_USE
                                                  : tsit_pkg::ST_DONE;
                        tsit_pkg::OP_QUALIFY:
                            state_next = (item.rec.score > 0 && full)
                                         ? tsit_pkg::ST_FETCH_USE : tsit_pkg::ST_DONE;
                        default:              state_next = tsit_pkg::ST_DONE;
                    endcase
                end
            end
            tsit_pkg::ST_SCAN_RD:
            begin
                if (!scan_end)
                begin
                    state_next = tsit_pkg::ST_SCAN_CMP;
                end
                else if (ptr_reg == DEPTH_CNT)
                begin
                    state_next = tsit_pkg::ST_DONE;
                end
                else
                begin
                    state_next = tsit_pkg::ST_SHIFT_RD;
                end
            end
            tsit_pkg::ST_SCAN_CMP:
                state_next = cmp_gt ? tsit_pkg::ST_SHIFT_RD : tsit_pkg::ST_SCAN_RD;
            tsit_pkg::ST_SHIFT_RD:
                state_next = (ptr_reg == rank_reg) ? tsit_pkg::ST_PLACE
                                                   : tsit_pkg::ST_SHIFT_WR;
            tsit_pkg::ST_SHIFT_WR:  state_next = tsit_pkg::ST_SHIFT_RD;
            tsit_pkg::ST_PLACE:     state_next = tsit_pkg::ST_DONE;
            tsit_pkg::ST_FETCH_USE: state_next = tsit_pkg::ST_DONE;
            tsit_pkg::ST_DONE:
                state_next = cmd.out_free ? tsit_pkg::ST_IDLE : tsit_pkg::ST_DONE;
            default:                state_next = tsit_pkg::ST_IDLE;
        endcase
    end

    // Datapath control and memory access
    always_comb
    begin
        item_next       = item_reg;
        cnt_next        = cnt_reg;
        ptr_next        = ptr_reg;
        rank_next       = rank_reg;
        best_next       = best_reg;
        res_next        = res_reg;
        mem_ctl         = '0;
        wr_data         = rd_data;
        unique case (state_reg)
            tsit_pkg::ST_IDLE:
            begin
                if (cmd.start)
                begin
                    item_next = item;
                    ptr_next  = '0;
                    res_next  = '0;
                    if (item.op == tsit_pkg::OP_READ)
                    begin
                        mem_ctl.rd_en   = read_hit;
                        mem_ctl.rd_addr = item.entry_index[tsit_pkg::IDX_W-1:0];
                    end
                    else if (item.op == tsit_pkg::OP_QUALIFY)
                    begin
                        mem_ctl.rd_en       = 1'b1;
                        mem_ctl.rd_addr     = LAST_IDX;
                        res_next.qualifies  = (item.rec.score > 0) && !full;
                    end
                end
            end
            tsit_pkg::ST_SCAN_RD:
            begin
                if (!scan_end)
                begin
                    mem_ctl.rd_en   = 1'b1;
                    mem_ctl.rd_addr = ptr_reg[tsit_pkg::IDX_W-1:0];
                end
                else
                begin
                    // No lower entry: append at the fill count
                    rank_next = ptr_reg;
                    ptr_next  = shift_last;
                end
            end
            tsit_pkg::ST_SCAN_CMP:
            begin
                if (cmp_gt)
                begin
                    rank_next = ptr_reg;
                    ptr_next  = shift_last;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            tsit_pkg::ST_SHIFT_RD:
            begin
                if (ptr_reg != rank_reg)
                begin
                    mem_ctl.rd_en   = 1'b1;
                    mem_ctl.rd_addr = tsit_pkg::IDX_W'(ptr_reg - 1'b1);
                end
            end
            tsit_pkg::ST_SHIFT_WR:
            begin
                // Move the entry above down one place
                mem_ctl.wr_en   = 1'b1;
                mem_ctl.wr_addr = ptr_reg[tsit_pkg::IDX_W-1:0];
                wr_data         = rd_data;
                ptr_next        = ptr_reg - 1'b1;
            end
            tsit_pkg::ST_PLACE:
            begin
                mem_ctl.wr_en   = 1'b1;
                mem_ctl.wr_addr = rank_reg[tsit_pkg::IDX_W-1:0];
                wr_data         = item_reg.rec;
                if (!full)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (rank_reg == '0)
                begin
                    best_next = item_reg.rec.score;
                end
                res_next.placed = 1'b1;
                res_next.rank   = 6'(rank_reg);
            end
            tsit_pkg::ST_FETCH_USE:
            begin
                if (item_reg.op == tsit_pkg::OP_READ)
                begin
                    res_next.entry_valid = 1'b1;
                    res_next.entry_score = rd_data.score;
                    res_next.entry_level = rd_data.level;
                    res_next.entry_lines = rd_data.lines;
                    res_next.entry_name  = rd_data.name;
                end
                else
                begin
                    res_next.qualifies = cmp_gt;
                end
            end
            tsit_pkg::ST_DONE:
            begin
                mem_ctl = '0;
            end
            default:
            begin
                mem_ctl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tsit_pkg::ST_IDLE;
            cnt_reg   <= '0;
            best_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            best_reg  <= best_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        ptr_reg  <= ptr_next;
        rank_reg <= rank_next;
        res_reg  <= res_next;
    end

    // Report status and the finished result
    always_comb
    begin
        stat.idle       = (state_reg == tsit_pkg::ST_IDLE);
        stat.done       = (state_reg == tsit_pkg::ST_DONE);
        rsp             = res_reg;
        rsp.fill_count  = 7'(cnt_reg);
        rsp.best_score  = (cnt_reg == '0) ? 32'sd0 : best_reg;
    end

endmodule

// ===== rtl/core/topk_sorted_insert_table.sv =====
// Channel  Modport  Transaction
// -------  -------  ------------------------------------------------------
// req      sink     op, score, level, lines, name_bytes, entry_index
// rsp      source   placed, rank, qualifies, entry_valid, entry_*, fill_count,
//                   best_score
//
// One item at a time; req.ready is high only while the sequencer is idle.
// Insert scans from the top, reading and comparing one entry at a time until it meets
// a lower score, then moves the entries from that rank on down one place (read, then
// write) and writes the record in its place; compares and shifts together never exceed
// DEPTH. Read and qualify fetch at most one entry before the result is ready.
// A finished result sits in the rsp register;
// the next item is accepted while it waits, and holds in its last step until
// the register frees. Reset empties the table; the record memory is not cleared.
module topk_sorted_insert_table (
    input  logic clk,
    input  logic rst_n,
    tsit_req_if.sink   req,
    tsit_rsp_if.source rsp
);

    tsit_pkg::seq_cmd_t  cmd;
    tsit_pkg::seq_stat_t stat;
    tsit_pkg::item_t     item;
    tsit_pkg::rsp_t      seq_rsp;

    logic                rsp_valid_reg, rsp_valid_next;
    tsit_pkg::rsp_t      rsp_reg;
    logic                out_free;
    logic                out_load;

    // Accept only when the sequencer is idle
    assign req.ready = stat.idle;

    // Clean the name on the way in
    always_comb
    begin
        item.op          = tsit_pkg::op_t'(req.op);
        item.rec.score   = req.score;
        item.rec.level   = req.level;
        item.rec.lines   = req.lines;
        item.rec.name    = tsit_pkg::clean_name(req.name_bytes);
        item.entry_index = req.entry_index;
    end

    assign out_free     = !rsp_valid_reg || rsp.ready;
    assign out_load     = stat.done && out_free;
    assign cmd.start    = req.valid && req.ready;
    assign cmd.out_free = out_free;

    tsit_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .item  (item),
        .stat  (stat),
        .rsp   (seq_rsp)
    );

    // Hold the result until taken
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            rsp_reg <= seq_rsp;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.placed      = rsp_reg.placed;
    assign rsp.rank        = rsp_reg.rank;
    assign rsp.qualifies   = rsp_reg.qualifies;
    assign rsp.entry_valid = rsp_reg.entry_valid;
    assign rsp.entry_score = rsp_reg.entry_score;
    assign rsp.entry_level = rsp_reg.entry_level;
    assign rsp.entry_lines = rsp_reg.entry_lines;
    assign rsp.entry_name  = rsp_reg.entry_name;
    assign rsp.fill_count  = rsp_reg.fill_count;
    assign rsp.best_score  = rsp_reg.best_score;

endmodule
